@@ design/cwcs_pkg.sv @@
// ----------------------------------------------------------------------------
// cwcs_pkg
// shared types and constants of the candle window chart scaler
// ----------------------------------------------------------------------------
package cwcs_pkg;

  localparam int unsigned DefWindow = 32;
  localparam int unsigned PriceW    = 31;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned RowW      = 8;
  localparam int unsigned NumW      = 40;   // magnitude of (price - low) * scale

  // item kinds
  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_UPDATE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_PANEL_TOP    = 2'd0;
  localparam logic [1:0] CFG_PANEL_BOTTOM = 2'd1;
  localparam logic [1:0] CFG_CANDLE_PITCH = 2'd2;

  // mapping constants shared by all row lanes
  typedef struct packed {
    logic signed [31:0] span;    // window high - window low
    logic signed [9:0]  scale;   // panel_top - 1 - panel_bottom
    logic [RowW-1:0]    bottom;
  } map_cfg_t;

  typedef enum logic [2:0] {
    LP_IDLE,
    LP_MUL,
    LP_DIV,
    LP_FIN,
    LP_DONE
  } lane_phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STAT,
    S_SCAN_RD,
    S_SCAN_ACC,
    S_RD,
    S_LD,
    S_MAP,
    S_OUT
  } ctl_state_e;

endpackage

@@ design/cwcs_ram.sv @@
// ----------------------------------------------------------------------------
// cwcs_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module cwcs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/cwcs_row_lane.sv @@
// ----------------------------------------------------------------------------
// cwcs_row_lane
// maps one price to a pixel row: multiply, bit-serial divide, saturate
// ----------------------------------------------------------------------------
module cwcs_row_lane import cwcs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PriceW-1:0] price_i,
  input  logic [PriceW-1:0] low_i,
  input  map_cfg_t          mcfg_i,
  output logic [RowW-1:0]   row_o,
  output logic              done_o
);

  lane_phase_e phase_q, phase_d;

  logic signed [31:0] diff_q;
  logic [NumW-1:0]    num_q;
  logic [31:0]        rem_q;
  logic [PriceW-1:0]  div_q;
  logic               neg_q;
  logic [5:0]         cnt_q;
  logic [RowW-1:0]    row_q;

  logic signed [41:0] prod;
  logic [41:0]        prod_mag;
  logic [31:0]        span_mag;
  logic [31:0]        trial;
  logic               fit;
  logic signed [41:0] quot;
  logic signed [41:0] rsum;
  logic [RowW-1:0]    row_d;

  assign prod     = diff_q * mcfg_i.scale;
  assign prod_mag = prod[41] ? -prod : prod;
  assign span_mag = mcfg_i.span[31] ? -mcfg_i.span : mcfg_i.span;
  assign trial    = {rem_q[30:0], num_q[NumW-1]};
  assign fit      = trial >= {1'b0, div_q};

  always_comb begin
    quot = neg_q ? -$signed({2'b00, num_q}) : $signed({2'b00, num_q});
    rsum = quot + $signed({34'd0, mcfg_i.bottom});
    if (mcfg_i.span == '0) begin
      row_d = mcfg_i.bottom;
    end else if (rsum < 0) begin
      row_d = '0;
    end else if (rsum > 42'sd255) begin
      row_d = '1;
    end else begin
      row_d = rsum[RowW-1:0];
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      LP_IDLE: if (start_i) phase_d = LP_MUL;
      LP_MUL:  phase_d = LP_DIV;
      LP_DIV:  if (cnt_q == 6'd1) phase_d = LP_FIN;
      LP_FIN:  phase_d = LP_DONE;
      LP_DONE: phase_d = LP_IDLE;
      default: phase_d = LP_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done_o = (phase_q == LP_DONE);
    row_o  = row_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= LP_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      LP_IDLE: begin
        if (start_i) begin
          diff_q <= $signed({1'b0, price_i}) - $signed({1'b0, low_i});
        end
      end
      LP_MUL: begin
        num_q <= prod_mag[NumW-1:0];
        neg_q <= prod[41] ^ mcfg_i.span[31];
        div_q <= span_mag[PriceW-1:0];
        rem_q <= '0;
        cnt_q <= 6'(NumW);
      end
      LP_DIV: begin
        // one quotient bit per cycle, shifted in behind the numerator
        rem_q <= fit ? trial - {1'b0, div_q} : trial;
        num_q <= {num_q[NumW-2:0], fit};
        cnt_q <= cnt_q - 6'd1;
      end
      LP_FIN:  row_q <= row_d;
      default: ;
    endcase
  end

endmodule

@@ design/candle_window_chart_scaler.sv @@
// ----------------------------------------------------------------------------
// candle_window_chart_scaler
// ring of recent price candles with window high / low and pixel row mapping
// ----------------------------------------------------------------------------
//  channel  direction  handshake                    payload
//  input    in         in_valid_i / in_ready_o      func, times, four prices
//  output   out        out_valid_o / out_ready_i    geometry or status
//  config   in         cfg_we_i (no wait)           cfg_index_i, cfg_data_i
//
//  append, clear, unused kinds and status-only updates pass through S_STAT; the
//  input is free again once the status is loaded into the output register
//  each drawn slot runs through the 40-step bit-serial divider in the row
//  lanes; a successor update first reads back every slot of the candle ram
//  to rescan the window high and low
//  reset clears all control state; the candle ram holds no reset
//  a stalled output holds the walk, no new transaction is taken until done
// ----------------------------------------------------------------------------
module candle_window_chart_scaler import cwcs_pkg::*; #(
  parameter int unsigned Window = DefWindow
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  // input transactions
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  input  logic [TimeW-1:0]  open_time_i,
  input  logic [TimeW-1:0]  close_time_i,
  input  logic [PriceW-1:0] open_price_i,
  input  logic [PriceW-1:0] high_price_i,
  input  logic [PriceW-1:0] low_price_i,
  input  logic [PriceW-1:0] close_price_i,
  // output transactions
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              draw_o,
  output logic [5:0]        slot_o,
  output logic [9:0]        x_pos_o,
  output logic [RowW-1:0]   open_y_o,
  output logic [RowW-1:0]   high_y_o,
  output logic [RowW-1:0]   low_y_o,
  output logic [RowW-1:0]   close_y_o,
  output logic              falling_o,
  output logic              status_o,
  output logic [PriceW-1:0] max_price_o,
  output logic [PriceW-1:0] min_price_o,
  output logic              last_o
);

  localparam int unsigned IW = $clog2(Window);      // ring index
  localparam int unsigned FW = $clog2(Window + 1);  // fill count / slot
  localparam int unsigned CW = 4 * PriceW;          // one candle in ram

  // ring wrap of a sum below twice the window
  function automatic logic [IW-1:0] wrap(input logic [IW:0] v);
    logic [IW:0] w;
    w = (IW+1)'(Window);
    return (v >= w) ? IW'(v - w) : v[IW-1:0];
  endfunction

  ctl_state_e state_q, state_d;

  // configuration registers
  logic [7:0] panel_top_q, panel_bottom_q;
  logic [4:0] pitch_q;

  // window state
  logic [IW-1:0]     oldest_q;
  logic [FW-1:0]     fill_q;
  logic [TimeW-1:0]  newest_open_q, newest_close_q;
  logic [PriceW-1:0] hi_q, lo_q;

  // walk control
  logic [FW-1:0] slot_q, last_slot_q;
  logic          stat_code_q;

  // output register
  logic              out_valid_q;
  logic              draw_q, falling_q, status_q, last_q;
  logic [5:0]        slot_out_q;
  logic [9:0]        x_q;
  logic [RowW-1:0]   oy_q, hy_q, ly_q, cy_q;
  logic [PriceW-1:0] max_q, min_q;

  // ram
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0] ram_rdata;
  logic [PriceW-1:0] rd_open, rd_high, rd_low, rd_close;

  // lanes
  logic          lane_start;
  map_cfg_t      mcfg;
  logic [RowW-1:0] row_open, row_high, row_low, row_close;
  logic [3:0]    lane_done;

  // decode of the current transaction
  logic          accept, out_free, out_load;
  logic          upd_later, upd_succ, upd_same, widen_hi, widen_lo;
  logic [IW:0]   fill_ext;
  logic [10:0]   x_full;

  assign accept    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  // a new result enters the output register
  assign out_load  = ((state_q == S_STAT) || (state_q == S_OUT)) && out_free;
  assign fill_ext  = (IW+1)'(fill_q);
  assign upd_later = newest_open_q < open_time_i;
  assign upd_succ  = upd_later && (newest_close_q == open_time_i);
  assign upd_same  = newest_open_q == open_time_i;
  assign widen_hi  = high_price_i > hi_q;
  assign widen_lo  = low_price_i < lo_q;

  assign {rd_open, rd_high, rd_low, rd_close} = ram_rdata;

  assign mcfg.span   = $signed({1'b0, hi_q}) - $signed({1'b0, lo_q});
  assign mcfg.scale  = $signed({2'b00, panel_top_q}) - 10'sd1
                       - $signed({2'b00, panel_bottom_q});
  assign mcfg.bottom = panel_bottom_q;

  assign x_full = 11'(slot_q) * 11'(pitch_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_STAT;
          if (func_i == FUNC_UPDATE && fill_q != '0) begin
            if (upd_succ) begin
              state_d = S_SCAN_RD;
            end else if (!upd_later && upd_same) begin
              state_d = S_RD;
            end
          end
        end
      end
      S_STAT:     if (out_free) state_d = S_IDLE;
      S_SCAN_RD:  state_d = S_SCAN_ACC;
      S_SCAN_ACC: if (slot_q == last_slot_q) state_d = S_RD; else state_d = S_SCAN_RD;
      S_RD:       state_d = S_LD;
      S_LD:       state_d = S_MAP;
      S_MAP:      if (lane_done[0]) state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = (slot_q == last_slot_q) ? S_IDLE : S_RD;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    lane_start = (state_q == S_LD);
    ram_we     = 1'b0;
    ram_waddr  = oldest_q;
    ram_raddr  = wrap((IW+1)'(oldest_q) + (IW+1)'(slot_q));
    if (accept) begin
      case (func_i)
        FUNC_APPEND: begin
          ram_we    = 1'b1;
          ram_waddr = (fill_q < FW'(Window)) ? wrap((IW+1)'(oldest_q) + fill_ext) : oldest_q;
        end
        FUNC_UPDATE: begin
          if (fill_q != '0) begin
            if (upd_succ) begin
              ram_we    = 1'b1;
              ram_waddr = wrap((IW+1)'(oldest_q) + fill_ext);
            end else if (!upd_later && upd_same) begin
              ram_we    = 1'b1;
              ram_waddr = wrap((IW+1)'(oldest_q) + fill_ext - (IW+1)'(1));
            end
          end
        end
        default: ;
      endcase
    end
  end

  cwcs_ram #(
    .Width (CW),
    .Depth (Window)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({open_price_i, high_price_i, low_price_i, close_price_i}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // four lanes, one per price of the slot, sharing span and scale
  cwcs_row_lane u_lane_open (
    .clk_i, .rst_ni, .start_i (lane_start), .price_i (rd_open), .low_i (lo_q),
    .mcfg_i (mcfg), .row_o (row_open), .done_o (lane_done[0])
  );
  cwcs_row_lane u_lane_high (
    .clk_i, .rst_ni, .start_i (lane_start), .price_i (rd_high), .low_i (lo_q),
    .mcfg_i (mcfg), .row_o (row_high), .done_o (lane_done[1])
  );
  cwcs_row_lane u_lane_low (
    .clk_i, .rst_ni, .start_i (lane_start), .price_i (rd_low), .low_i (lo_q),
    .mcfg_i (mcfg), .row_o (row_low), .done_o (lane_done[2])
  );
  cwcs_row_lane u_lane_close (
    .clk_i, .rst_ni, .start_i (lane_start), .price_i (rd_close), .low_i (lo_q),
    .mcfg_i (mcfg), .row_o (row_close), .done_o (lane_done[3])
  );

  // control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      panel_top_q    <= 8'd16;
      panel_bottom_q <= 8'd63;
      pitch_q        <= 5'd4;
      oldest_q       <= '0;
      fill_q         <= '0;
      newest_open_q  <= '0;
      newest_close_q <= '0;
      hi_q           <= '0;
      lo_q           <= '1;
      slot_q         <= '0;
      last_slot_q    <= '0;
      stat_code_q    <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PANEL_TOP:    panel_top_q    <= cfg_data_i;
          CFG_PANEL_BOTTOM: panel_bottom_q <= cfg_data_i;
          CFG_CANDLE_PITCH: pitch_q        <= cfg_data_i[4:0];
          default: ;
        endcase
      end

      // output register: set by a new result, cleared once taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            stat_code_q <= 1'b0;
            case (func_i)
              FUNC_APPEND: begin
                if (fill_q < FW'(Window)) begin
                  fill_q <= fill_q + FW'(1);
                end else begin
                  oldest_q <= wrap((IW+1)'(oldest_q) + (IW+1)'(1));
                end
                newest_open_q  <= open_time_i;
                newest_close_q <= close_time_i;
                if (widen_hi) hi_q <= high_price_i;
                if (widen_lo) lo_q <= low_price_i;
              end
              FUNC_CLEAR: begin
                oldest_q       <= '0;
                fill_q         <= '0;
                newest_open_q  <= '0;
                newest_close_q <= '0;
                hi_q           <= '0;
                lo_q           <= '1;
              end
              FUNC_UPDATE: begin
                last_slot_q <= fill_q - FW'(1);
                if (fill_q == '0) begin
                  stat_code_q <= 1'b1;
                end else if (upd_later) begin
                  if (upd_succ) begin
                    // drop oldest, append new, rescan the window
                    oldest_q       <= wrap((IW+1)'(oldest_q) + (IW+1)'(1));
                    newest_open_q  <= open_time_i;
                    newest_close_q <= close_time_i;
                    hi_q           <= '0;
                    lo_q           <= '1;
                    slot_q         <= '0;
                  end else begin
                    stat_code_q <= 1'b1;
                  end
                end else if (upd_same) begin
                  newest_close_q <= close_time_i;
                  if (widen_hi) hi_q <= high_price_i;
                  if (widen_lo) lo_q <= low_price_i;
                  // a widened range redraws everything
                  slot_q <= (widen_hi || widen_lo) ? '0 : fill_q - FW'(1);
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN_ACC: begin
          if (rd_high > hi_q) hi_q <= rd_high;
          if (rd_low < lo_q)  lo_q <= rd_low;
          slot_q <= (slot_q == last_slot_q) ? '0 : slot_q + FW'(1);
        end
        S_OUT: begin
          if (out_free) begin
            slot_q <= slot_q + FW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_STAT && out_free) begin
      draw_q     <= 1'b0;
      slot_out_q <= '0;
      x_q        <= '0;
      oy_q       <= '0;
      hy_q       <= '0;
      ly_q       <= '0;
      cy_q       <= '0;
      falling_q  <= 1'b0;
      status_q   <= stat_code_q;
      max_q      <= hi_q;
      min_q      <= lo_q;
      last_q     <= 1'b1;
    end else if (state_q == S_OUT && out_free) begin
      draw_q     <= 1'b1;
      slot_out_q <= 6'(slot_q);
      x_q        <= (x_full > 11'd1023) ? 10'd1023 : x_full[9:0];
      oy_q       <= row_open;
      hy_q       <= row_high;
      ly_q       <= row_low;
      cy_q       <= row_close;
      falling_q  <= row_close > row_open;
      status_q   <= 1'b0;
      max_q      <= hi_q;
      min_q      <= lo_q;
      last_q     <= (slot_q == last_slot_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign draw_o      = draw_q;
  assign slot_o      = slot_out_q;
  assign x_pos_o     = x_q;
  assign open_y_o    = oy_q;
  assign high_y_o    = hy_q;
  assign low_y_o     = ly_q;
  assign close_y_o   = cy_q;
  assign falling_o   = falling_q;
  assign status_o    = status_q;
  assign max_price_o = max_q;
  assign min_price_o = min_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(Window))
    else $error("fill count beyond window");

  a_oldest_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (IW+1)'(oldest_q) < (IW+1)'(Window))
    else $error("oldest index beyond window");

  a_lane_done_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_done[0] |-> (state_q == S_MAP) && (lane_done == 4'hF))
    else $error("row lanes finished out of step");

  a_draw_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> (fill_q != '0) && (slot_q <= last_slot_q))
    else $error("drawing a slot outside the window");
`endif

endmodule
